// ===== hdl/first_fit_block_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// First-fit block allocator assertion macros
// Wrappers for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define FFBA_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FFBA_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// First-fit block allocator package
// Status codes and fixed port widths.
// ----------------------------------------------------------------------------
package ffba_pkg;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DEFRAG  = 3'd1,
    ST_NOSPACE = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  localparam int unsigned FIELD_W = 32;
  localparam int unsigned TDATA_W = 64;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

endpackage

// ===== hdl/ffba_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/first_fit_block_allocator.sv =====
// Sequence: allocate scans the free list for a first fit and shifts it out; release
//   finds and shifts out the used entry; a failed fit adds bubble-sort passes until
//   no swap, one merge pass, and a second scan.
// Flow: one item at a time; list steps read and write the single-read-port
//   list memories. Result held in an output register.
// Reset: asynchronous; used count 0, free count 1; free entry 0 is (0, 0) until written.
// ----------------------------------------------------------------------------
// First-fit block allocator
// Free and used lists of (start, length) in RAM, walked by a sequencer.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
  parameter int unsigned FREE_ENTRIES = 64,
  parameter int unsigned USED_ENTRIES = 64,
  parameter int unsigned ADDR_BITS    = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ffba_pkg::TDATA_W-1:0]    s_axis_tdata,  // alloc_size, block_start
  input  logic                            s_axis_tuser,  // kind
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ffba_pkg::TDATA_W-1:0]    m_axis_tdata,  // granted_start, granted_size
  output logic [2:0]                      m_axis_tuser,  // status
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ffba_pkg::PADDR_W-1:0]    paddr,
  input  logic [ffba_pkg::PDATA_W-1:0]    pwdata,
  output logic [ffba_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);
  import ffba_pkg::*;

  localparam int unsigned LW   = ADDR_BITS > FIELD_W ? ADDR_BITS : FIELD_W;
  localparam int unsigned EW   = ADDR_BITS + LW;
  localparam int unsigned FAW  = FREE_ENTRIES > 1 ? $clog2(FREE_ENTRIES) : 1;
  localparam int unsigned UAW  = USED_ENTRIES > 1 ? $clog2(USED_ENTRIES) : 1;
  localparam int unsigned FCW  = $clog2(FREE_ENTRIES + 1);
  localparam int unsigned UCW  = $clog2(USED_ENTRIES + 1);
  localparam int unsigned XW   = FCW > UCW ? FCW : UCW;
  localparam logic [LW-1:0] AMASK = LW'({ADDR_BITS{1'b1}});

  typedef enum logic [4:0] {
    S_IDLE, S_FIT_RD, S_FIT_CHK, S_FSH_RD, S_FSH_WR, S_UAPP,
    S_SRT_START, S_SRT_LD, S_SRT_RD, S_SRT_CMP,
    S_MRG_START, S_MRG_LD, S_MRG_RD, S_MRG_CMP,
    S_REL_RD, S_REL_CHK, S_USH_RD, S_USH_WR, S_DONE
  } state_e;

  state_e               state_q, state_d;
  logic [FCW-1:0]       fc_q, fc_d;
  logic [UCW-1:0]       uc_q, uc_d;
  logic [XW-1:0]        idx_q, idx_d;
  logic [FCW-1:0]       w_q, w_d;
  logic                 retry_q, retry_d;
  logic                 swap_q, swap_d;
  logic [FIELD_W-1:0]   req_q, req_d;
  logic [FIELD_W-1:0]   bs_q, bs_d;
  logic [ADDR_BITS-1:0] cs_q, cs_d;
  logic [LW-1:0]        cl_q, cl_d;
  logic [FIELD_W-1:0]   rs_q, rs_d, rl_q, rl_d;
  status_e              rst_q, rst_d;
  logic                 ov_q, ov_d;
  logic [FIELD_W-1:0]   os_q, os_d, ol_q, ol_d;
  status_e              ost_q, ost_d;
  logic [PDATA_W-1:0]   pool_q, pool_d;
  logic                 f0v_q, f0v_d;
  logic                 rd0_q;

  logic                 fwe, uwe;
  logic [FAW-1:0]       fwa, fra;
  logic [UAW-1:0]       uwa, ura;
  logic [EW-1:0]        fwd, uwd, frd_raw, frd, urd;

  logic [ADDR_BITS-1:0] x_s, u_s;
  logic [LW-1:0]        x_l, u_l;
  logic [LW:0]          msum;
  logic                 cfg_wr, acc_in;

  ffba_ram #(.WIDTH(EW), .DEPTH(FREE_ENTRIES)) u_free_ram (
    .clk_i, .we_i(fwe), .waddr_i(fwa), .wdata_i(fwd), .raddr_i(fra), .rdata_o(frd_raw)
  );
  ffba_ram #(.WIDTH(EW), .DEPTH(USED_ENTRIES)) u_used_ram (
    .clk_i, .we_i(uwe), .waddr_i(uwa), .wdata_i(uwd), .raddr_i(ura), .rdata_o(urd)
  );

  // entry 0 reads as (0, 0) until first written
  assign frd = (rd0_q && !f0v_q) ? '0 : frd_raw;
  assign x_s = frd[ADDR_BITS-1:0];
  assign x_l = frd[EW-1:ADDR_BITS];
  assign u_s = urd[ADDR_BITS-1:0];
  assign u_l = urd[EW-1:ADDR_BITS];
  assign msum = {1'b0, cl_q} + {1'b0, x_l};

  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
  assign acc_in = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign pready = 1'b1;
  assign prdata = !paddr[2] ? pool_q : '0;

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {ol_q, os_q};
  assign m_axis_tuser  = ost_q;

  always_comb begin
    state_d = state_q; fc_d = fc_q; uc_d = uc_q; idx_d = idx_q; w_d = w_q;
    retry_d = retry_q; swap_d = swap_q; req_d = req_q; bs_d = bs_q;
    cs_d = cs_q; cl_d = cl_q; rs_d = rs_q; rl_d = rl_q; rst_d = rst_q;
    ov_d = ov_q; os_d = os_q; ol_d = ol_q; ost_d = ost_q; pool_d = pool_q;
    fwe = 1'b0; fwa = '0; fwd = '0; fra = '0;
    uwe = 1'b0; uwa = '0; uwd = '0; ura = '0;

    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (acc_in) begin
          req_d  = s_axis_tdata[FIELD_W-1:0];
          bs_d   = s_axis_tdata[TDATA_W-1:FIELD_W];
          idx_d  = '0;
          retry_d = 1'b0;
          rs_d = FIELD_W'(1); rl_d = FIELD_W'(1);
          if (s_axis_tuser == KIND_RELEASE) begin
            state_d = S_REL_RD;
          end else if (uc_q >= UCW'(USED_ENTRIES)) begin
            rst_d = ST_FULL;
            state_d = S_DONE;
          end else begin
            state_d = S_FIT_RD;
          end
        end
      end
      S_FIT_RD: begin
        if (idx_q >= XW'(fc_q)) begin
          if (retry_q) begin
            rst_d = ST_NOSPACE;
            state_d = S_DONE;
          end else begin
            retry_d = 1'b1;
            state_d = S_SRT_START;
          end
        end else begin
          fra = idx_q[FAW-1:0];
          state_d = S_FIT_CHK;
        end
      end
      S_FIT_CHK: begin
        if (x_l >= LW'(req_q)) begin
          cs_d = x_s; cl_d = x_l;
          state_d = S_FSH_RD;
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = S_FIT_RD;
        end
      end
      S_FSH_RD: begin
        if (({1'b0, idx_q} + 1'b1) < (XW + 1)'(fc_q)) begin
          fra = FAW'(idx_q + 1'b1);
          state_d = S_FSH_WR;
        end else begin
          fc_d = fc_q - 1'b1;
          state_d = S_UAPP;
        end
      end
      S_FSH_WR: begin
        fwe = 1'b1; fwa = idx_q[FAW-1:0]; fwd = frd;
        idx_d = idx_q + 1'b1;
        state_d = S_FSH_RD;
      end
      S_UAPP: begin
        uwe = 1'b1; uwa = uc_q[UAW-1:0]; uwd = {LW'(req_q), cs_q};
        uc_d = uc_q + 1'b1;
        if (cl_q > LW'(req_q)) begin
          fwe = 1'b1; fwa = fc_q[FAW-1:0];
          fwd = {cl_q - LW'(req_q), ADDR_BITS'(LW'(cs_q) + LW'(req_q))};
          fc_d = fc_q + 1'b1;
        end
        rs_d = FIELD_W'(LW'(cs_q));
        rl_d = req_q;
        rst_d = retry_q ? ST_DEFRAG : ST_OK;
        state_d = S_DONE;
      end
      S_SRT_START: begin
        if (fc_q <= FCW'(1)) begin
          state_d = S_MRG_START;
        end else begin
          swap_d = 1'b0;
          fra = '0;
          idx_d = XW'(1);
          state_d = S_SRT_LD;
        end
      end
      S_SRT_LD: begin
        cs_d = x_s; cl_d = x_l;
        state_d = S_SRT_RD;
      end
      S_SRT_RD: begin
        if (idx_q < XW'(fc_q)) begin
          fra = idx_q[FAW-1:0];
          state_d = S_SRT_CMP;
        end else begin
          fwe = 1'b1; fwa = FAW'(fc_q - 1'b1); fwd = {cl_q, cs_q};
          state_d = swap_q ? S_SRT_START : S_MRG_START;
        end
      end
      S_SRT_CMP: begin
        fwe = 1'b1; fwa = FAW'(idx_q - 1'b1);
        if (cs_q > x_s || (cs_q == x_s && cl_q > x_l)) begin
          fwd = frd;
          swap_d = 1'b1;
        end else begin
          fwd = {cl_q, cs_q};
          cs_d = x_s; cl_d = x_l;
        end
        idx_d = idx_q + 1'b1;
        state_d = S_SRT_RD;
      end
      S_MRG_START: begin
        idx_d = '0;
        if (fc_q == '0) begin
          state_d = S_FIT_RD;
        end else begin
          fra = '0;
          idx_d = XW'(1);
          w_d = '0;
          state_d = S_MRG_LD;
        end
      end
      S_MRG_LD: begin
        cs_d = x_s; cl_d = x_l;
        state_d = S_MRG_RD;
      end
      S_MRG_RD: begin
        if (idx_q < XW'(fc_q)) begin
          fra = idx_q[FAW-1:0];
          state_d = S_MRG_CMP;
        end else begin
          fwe = 1'b1; fwa = w_q[FAW-1:0]; fwd = {cl_q, cs_q};
          fc_d = w_q + 1'b1;
          idx_d = '0;
          state_d = S_FIT_RD;
        end
      end
      S_MRG_CMP: begin
        if (ADDR_BITS'(LW'(cs_q) + cl_q) == x_s) begin
          cl_d = ((msum >> ADDR_BITS) != '0) ? AMASK : msum[LW-1:0];
        end else begin
          fwe = 1'b1; fwa = w_q[FAW-1:0]; fwd = {cl_q, cs_q};
          w_d = w_q + 1'b1;
          cs_d = x_s; cl_d = x_l;
        end
        idx_d = idx_q + 1'b1;
        state_d = S_MRG_RD;
      end
      S_REL_RD: begin
        if (idx_q >= XW'(uc_q)) begin
          rst_d = ST_UNKNOWN;
          state_d = S_DONE;
        end else begin
          ura = idx_q[UAW-1:0];
          state_d = S_REL_CHK;
        end
      end
      S_REL_CHK: begin
        if (LW'(u_s) == LW'(bs_q)) begin
          if (fc_q >= FCW'(FREE_ENTRIES)) begin
            rst_d = ST_FULL;
            state_d = S_DONE;
          end else begin
            cs_d = u_s; cl_d = u_l;
            state_d = S_USH_RD;
          end
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = S_REL_RD;
        end
      end
      S_USH_RD: begin
        if (({1'b0, idx_q} + 1'b1) < (XW + 1)'(uc_q)) begin
          ura = UAW'(idx_q + 1'b1);
          state_d = S_USH_WR;
        end else begin
          uc_d = uc_q - 1'b1;
          fwe = 1'b1; fwa = fc_q[FAW-1:0]; fwd = {cl_q, cs_q};
          fc_d = fc_q + 1'b1;
          rs_d = FIELD_W'(LW'(cs_q));
          rl_d = cl_q[FIELD_W-1:0];
          rst_d = ST_OK;
          state_d = S_DONE;
        end
      end
      S_USH_WR: begin
        uwe = 1'b1; uwa = idx_q[UAW-1:0]; uwd = urd;
        idx_d = idx_q + 1'b1;
        state_d = S_USH_RD;
      end
      S_DONE: begin
        if (!ov_q || m_axis_tready) begin
          ov_d = 1'b1; os_d = rs_q; ol_d = rl_q; ost_d = rst_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_wr) begin
      pool_d = pwdata;
      fc_d = FCW'(1);
      uc_d = '0;
      fwe = 1'b1; fwa = '0;
      fwd = {LW'(pwdata) & AMASK, {ADDR_BITS{1'b0}}};
    end
  end

  assign f0v_d = f0v_q || (fwe && fwa == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fc_q    <= FCW'(1);
      uc_q    <= '0;
      idx_q   <= '0;
      w_q     <= '0;
      retry_q <= 1'b0;
      swap_q  <= 1'b0;
      ov_q    <= 1'b0;
      pool_q  <= '0;
      f0v_q   <= 1'b0;
      rd0_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fc_q    <= fc_d;
      uc_q    <= uc_d;
      idx_q   <= idx_d;
      w_q     <= w_d;
      retry_q <= retry_d;
      swap_q  <= swap_d;
      ov_q    <= ov_d;
      pool_q  <= pool_d;
      f0v_q   <= f0v_d;
      rd0_q   <= (fra == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    bs_q   <= bs_d;
    cs_q   <= cs_d;
    cl_q   <= cl_d;
    rs_q   <= rs_d;
    rl_q   <= rl_d;
    rst_q  <= rst_d;
    os_q   <= os_d;
    ol_q   <= ol_d;
    ost_q  <= ost_d;
  end

endmodule

// ===== hdl/ffba_checker.sv =====
// ----------------------------------------------------------------------------
// First-fit block allocator checker
// Port-level checks on result beats and input pacing.
// ----------------------------------------------------------------------------
`include "first_fit_block_allocator_macros.svh"

module ffba_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);
  import ffba_pkg::*;

  `FFBA_ASSERT_IMP(a_status_legal, clk_i, rst_ni, m_axis_tvalid, m_axis_tuser <= ST_FULL, "illegal status")
  `FFBA_ASSERT_IMP(a_fail_result, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == ST_NOSPACE || m_axis_tuser == ST_UNKNOWN || m_axis_tuser == ST_FULL), m_axis_tdata[31:0] == 32'd1 && m_axis_tdata[63:32] == 32'd1, "failure beat not (1, 1)")
  `FFBA_ASSERT_NXT(a_one_at_a_time, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")
  `FFBA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat dropped or changed")

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);
